// ===== hw/rtl/ira_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the radix ASCII converter.
// Used by ira_div and integer_to_radix_ascii; depends on nothing else.
package ira_pkg;

  // Default width of the converted integer
  localparam int unsigned VALUE_BITS_DEFAULT = 64;

  // Width of the radix register and of one digit value
  localparam int unsigned RADIX_W = 6;

  // Radix limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // Quotient bits resolved per divider cycle
  localparam int unsigned DIV_BITS_PER_CYCLE = 8;

  // ASCII codes
  localparam int unsigned CHAR_W = 7;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;
  localparam logic [CHAR_W-1:0] ASCII_Z    = 7'd90;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // Clamp the register value into the legal radix range
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  // Map a digit value 0..35 to '0'..'9', 'A'..'Z'
  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_DIGITS) begin
      res = ASCII_ZERO + CHAR_W'(d);
    end else begin
      res = ASCII_A + CHAR_W'(d - DEC_DIGITS);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/ira_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module ira_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds between reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ira_div.sv =====
`timescale 1ns / 1ps
// Iterative restoring divider: divides a VALUE_BITS dividend by a 6-bit radix,
// DIV_BITS_PER_CYCLE quotient bits per cycle. Depends on ira_pkg.
module ira_div #(
  parameter int unsigned VALUE_BITS = ira_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [VALUE_BITS-1:0]        dividend_i,
  input  logic [ira_pkg::RADIX_W-1:0]  radix_i,
  output logic                         done_o,
  output logic [VALUE_BITS-1:0]        quotient_o,
  output logic [ira_pkg::RADIX_W-1:0]  remainder_o
);
  import ira_pkg::*;

  localparam int unsigned Steps = (VALUE_BITS + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
  localparam int unsigned DivW  = Steps * DIV_BITS_PER_CYCLE;
  localparam int unsigned CntW  = (Steps > 1) ? $clog2(Steps) : 1;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [RADIX_W-1:0] rem_q, rem_d;

  // Resolve one group of quotient bits: shift in, compare, subtract
  always_comb begin
    logic [RADIX_W:0] r;
    logic [DivW-1:0]  q;
    r = {1'b0, rem_q};
    q = quo_q;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      r = {r[RADIX_W-1:0], q[DivW-1]};
      q = {q[DivW-2:0], 1'b0};
      if (r >= {1'b0, radix_i}) begin
        r    = r - {1'b0, radix_i};
        q[0] = 1'b1;
      end
    end

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = DivW'(dividend_i);
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = q;
      rem_d = r[RADIX_W-1:0];
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q[VALUE_BITS-1:0];
  assign remainder_o = rem_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < radix_i))
    else $error("remainder not below radix");

endmodule

// ===== hw/rtl/integer_to_radix_ascii.sv =====
`timescale 1ns / 1ps
// Top level of the radix ASCII converter: sequencer, digit memory, output register.
// Depends on ira_pkg, ira_div and ira_ram.
//
// Converts one integer per request into ASCII digits ('0'-'9', 'A'-'Z') in the
// radix held in the configuration register (0/1 act as 2, above 36 acts as 36).
// Digits leave most significant first, one per output request, tlast on the
// final one; tuser flags every digit of a negative signed conversion. Each
// digit is one division of the remaining value on the shared divider,
// whose remainders are written least significant first into the digit memory;
// the memory is then read back in reverse at one digit per cycle while the
// output is not stalled. A new request is taken once the last digit has
// moved into the output register.
module integer_to_radix_ascii #(
  parameter int unsigned VALUE_BITS = ira_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: radix register
  input  logic                        cfg_we_i,
  input  logic [ira_pkg::RADIX_W-1:0] cfg_wdata_i,
  // Input requests
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,  // [63:0] value
  input  logic                        s_axis_tuser,  // [0] signed_mode
  // Output requests
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // [6:0] digit_char, [7] zero
  output logic                        m_axis_tuser,  // [0] negative
  output logic                        m_axis_tlast
);
  import ira_pkg::*;

  localparam int unsigned AddrW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned CntW  = $clog2(VALUE_BITS + 1);

  state_e               state_q, state_d;
  logic [RADIX_W-1:0]   radix_q;
  logic                 neg_q;
  logic [AddrW-1:0]     wr_idx_q, wr_idx_d;
  logic [AddrW-1:0]     rd_addr_q, rd_addr_d;
  logic [CntW-1:0]      rd_left_q, rd_left_d;
  logic                 rd_pend_q, rd_pend_d;
  logic                 rd_last_q;
  logic                 m_valid_q, m_valid_d;
  logic [CHAR_W-1:0]    m_char_q;
  logic                 m_neg_q, m_last_q;

  logic                 in_acc;
  logic [VALUE_BITS-1:0] in_val, in_mag;
  logic                 in_neg;
  logic [RADIX_W-1:0]   radix_eff;
  logic                 div_start, div_done;
  logic [VALUE_BITS-1:0] div_dividend, div_quo;
  logic [RADIX_W-1:0]   div_rem;
  logic                 ram_we, ram_re;
  logic [RADIX_W-1:0]   ram_rdata;
  logic                 out_load;

  // Hold the radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  assign radix_eff = eff_radix(radix_q);

  // Accept requests while idle; take the magnitude of a negative signed input
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_val        = s_axis_tdata[VALUE_BITS-1:0];
  assign in_neg        = s_axis_tuser && in_val[VALUE_BITS-1];
  assign in_mag        = in_neg ? (~in_val + VALUE_BITS'(1)) : in_val;

  // Divider: start on a request, restart on each non-zero quotient
  assign ram_we       = (state_q == ST_DIV) && div_done;
  assign div_start    = in_acc || (ram_we && (div_quo != '0));
  assign div_dividend = in_acc ? in_mag : div_quo;

  ira_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .radix_i     (radix_eff),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Digit memory: written least significant first, read back in reverse.
  // Reading starts only after the final write, so no forwarding is needed.
  ira_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (VALUE_BITS),
    .AW    (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (div_rem),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  // Move a fetched digit into the output register when it is free
  assign out_load = rd_pend_q && (!m_valid_q || m_axis_tready);
  assign ram_re   = (state_q == ST_EMIT) && (rd_left_q != '0) && (!rd_pend_q || out_load);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    wr_idx_d  = wr_idx_q;
    rd_addr_d = rd_addr_q;
    rd_left_d = rd_left_q;
    rd_pend_d = rd_pend_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          wr_idx_d = '0;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_quo != '0) begin
            wr_idx_d = wr_idx_q + AddrW'(1);
          end else begin
            rd_addr_d = wr_idx_q;
            rd_left_d = CntW'(wr_idx_q) + CntW'(1);
            state_d   = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (ram_re) begin
          rd_addr_d = rd_addr_q - AddrW'(1);
          rd_left_d = rd_left_q - CntW'(1);
          rd_pend_d = 1'b1;
        end else if (out_load) begin
          rd_pend_d = 1'b0;
        end
        if ((rd_left_q == '0) && (!rd_pend_q || out_load)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wr_idx_q  <= '0;
      rd_addr_q <= '0;
      rd_left_q <= '0;
      rd_pend_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_idx_q  <= wr_idx_d;
      rd_addr_q <= rd_addr_d;
      rd_left_q <= rd_left_d;
      rd_pend_q <= rd_pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      neg_q <= in_neg;
    end
    if (ram_re) begin
      rd_last_q <= (rd_left_q == CntW'(1));
    end
    if (out_load) begin
      m_char_q <= digit_glyph(ram_rdata);
      m_neg_q  <= neg_q;
      m_last_q <= rd_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_char_q};
  assign m_axis_tuser  = m_neg_q;
  assign m_axis_tlast  = m_last_q;

  a_last_after_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && rd_last_q) |-> (rd_left_q == '0))
    else $error("final digit loaded while reads remain");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_char_q >= ASCII_ZERO) && (m_char_q <= ASCII_Z)))
    else $error("digit character out of range");

  a_no_stale_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!rd_pend_q && (rd_left_q == '0)))
    else $error("new request taken with digits still pending");

endmodule
